// ----- hw/rtl/dlp_pkg.sv -----
// Shared types and constants for the duration literal parser.
// Holds the token format, unit classes and the unit word table.
// No dependencies.
package dlp_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        UC_NONE, UC_SEC, UC_MIN, UC_HR, UC_DAY, UC_WK, UC_YR, UC_NS, UC_MS, UC_US
    } unit_cls_t;

    localparam int NUM_WORDS = 51;
    localparam int WORD_CHARS = 12;
    localparam int MUL_W = 25;

    typedef struct packed {
        logic [8*WORD_CHARS-1:0] word;  // right-justified, first char highest
        logic [3:0]              len;
        unit_cls_t               cls;
    } unit_entry_t;

    // one finished pair and/or end of text, from front to back
    typedef struct packed {
        logic       is_end;
        logic       do_pair;
        logic [63:0] number;
        logic       too_big;
        unit_cls_t  cls;
        logic       shape_err;
    } token_t;

    // second units come first so that "m" resolves to minutes
    function automatic unit_entry_t unit_entry(input int k);
        unit_entry_t e;
        case (k)
            0:  e = '{96'("s"), 4'd1, UC_SEC};
            1:  e = '{96'("sec"), 4'd3, UC_SEC};
            2:  e = '{96'("secs"), 4'd4, UC_SEC};
            3:  e = '{96'("seconds"), 4'd7, UC_SEC};
            4:  e = '{96'("m"), 4'd1, UC_MIN};
            5:  e = '{96'("min"), 4'd3, UC_MIN};
            6:  e = '{96'("mins"), 4'd4, UC_MIN};
            7:  e = '{96'("minutes"), 4'd7, UC_MIN};
            8:  e = '{96'("h"), 4'd1, UC_HR};
            9:  e = '{96'("hr"), 4'd2, UC_HR};
            10: e = '{96'("hrs"), 4'd3, UC_HR};
            11: e = '{96'("hours"), 4'd5, UC_HR};
            12: e = '{96'("d"), 4'd1, UC_DAY};
            13: e = '{96'("day"), 4'd3, UC_DAY};
            14: e = '{96'("days"), 4'd4, UC_DAY};
            15: e = '{96'("w"), 4'd1, UC_WK};
            16: e = '{96'("wk"), 4'd2, UC_WK};
            17: e = '{96'("wks"), 4'd3, UC_WK};
            18: e = '{96'("week"), 4'd4, UC_WK};
            19: e = '{96'("weeks"), 4'd5, UC_WK};
            20: e = '{96'("y"), 4'd1, UC_YR};
            21: e = '{96'("yr"), 4'd2, UC_YR};
            22: e = '{96'("yrs"), 4'd3, UC_YR};
            23: e = '{96'("year"), 4'd4, UC_YR};
            24: e = '{96'("years"), 4'd5, UC_YR};
            25: e = '{96'("n"), 4'd1, UC_NS};
            26: e = '{96'("ns"), 4'd2, UC_NS};
            27: e = '{96'("nsec"), 4'd4, UC_NS};
            28: e = '{96'("nsecs"), 4'd5, UC_NS};
            29: e = '{96'("nanosec"), 4'd7, UC_NS};
            30: e = '{96'("nanosecs"), 4'd8, UC_NS};
            31: e = '{96'("nanosecond"), 4'd10, UC_NS};
            32: e = '{96'("nanoseconds"), 4'd11, UC_NS};
            33: e = '{96'("m"), 4'd1, UC_MS};
            34: e = '{96'("ms"), 4'd2, UC_MS};
            35: e = '{96'("msec"), 4'd4, UC_MS};
            36: e = '{96'("msecs"), 4'd5, UC_MS};
            37: e = '{96'("millisec"), 4'd8, UC_MS};
            38: e = '{96'("millisecs"), 4'd9, UC_MS};
            39: e = '{96'("millisecond"), 4'd11, UC_MS};
            40: e = '{96'("milliseconds"), 4'd12, UC_MS};
            41: e = '{96'("microsec"), 4'd8, UC_US};
            42: e = '{96'("microsecs"), 4'd9, UC_US};
            43: e = '{96'("microsecond"), 4'd11, UC_US};
            44: e = '{96'("microseconds"), 4'd12, UC_US};
            45: e = '{96'("u"), 4'd1, UC_US};
            46: e = '{96'("us"), 4'd2, UC_US};
            47: e = '{96'("usec"), 4'd4, UC_US};
            48: e = '{96'("usecs"), 4'd5, UC_US};
            49: e = '{96'("usecond"), 4'd7, UC_US};
            50: e = '{96'("useconds"), 4'd8, UC_US};
            default: e = '{96'd0, 4'd0, UC_NONE};
        endcase
        return e;
    endfunction

    function automatic logic [MUL_W-1:0] cls_mult(input unit_cls_t c);
        logic [MUL_W-1:0] m;
        case (c)
            UC_SEC:  m = 25'd1;
            UC_MIN:  m = 25'd60;
            UC_HR:   m = 25'd3600;
            UC_DAY:  m = 25'd86400;
            UC_WK:   m = 25'd604800;
            UC_YR:   m = 25'd31536000;
            UC_NS:   m = 25'd1;
            UC_MS:   m = 25'd1000000;
            UC_US:   m = 25'd1000;
            default: m = 25'd0;
        endcase
        return m;
    endfunction

    function automatic logic cls_is_sec(input unit_cls_t c);
        return (c == UC_SEC) || (c == UC_MIN) || (c == UC_HR) || (c == UC_DAY) ||
               (c == UC_WK) || (c == UC_YR);
    endfunction

endpackage

// ----- hw/rtl/dlp_front.sv -----
// Front end: walks the text byte by byte, builds numbers and matches unit words.
// Emits one token per finished pair or end of text. Depends on dlp_pkg.
module dlp_front #(
    parameter int UNIT_MAX_CHARS = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_acc,
    input  logic [7:0]       text_byte,
    input  logic             end_marker,
    output logic             tok_push,
    output dlp_pkg::token_t  tok
);
    import dlp_pkg::*;

    localparam int LEN_W = $clog2(UNIT_MAX_CHARS + 1);

    typedef enum logic [2:0] {
        PH_START, PH_NUM, PH_SEP1, PH_UNIT, PH_SEP2, PH_BAD
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [63:0]            num_reg, num_next;
    logic                   big_reg, big_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   long_reg, long_next;
    logic [NUM_WORDS-1:0]   cand_reg, cand_next;
    logic                   shape_reg, shape_next;

    logic [NUM_WORDS-1:0]   hit;
    logic [NUM_WORDS-1:0]   full_match;
    unit_cls_t              word_cls [NUM_WORDS];
    logic [LEN_W-1:0]       pos;
    logic                   is_dig, is_sep, is_spc;
    logic [3:0]             dig;
    logic [67:0]            n10;
    unit_cls_t              cls;

    assign is_dig = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_spc = (text_byte == 8'h20) || (text_byte == 8'h2c);
    assign is_sep = is_spc || ((text_byte >= 8'd9) && (text_byte <= 8'd13));
    assign dig    = text_byte[3:0];
    assign n10    = {1'b0, num_reg, 3'b0} + {3'b0, num_reg, 1'b0} + {64'd0, dig};
    assign pos    = (phase_reg == PH_UNIT) ? len_reg : '0;

    // per-word compare of the incoming byte at the current position
    for (genvar k = 0; k < NUM_WORDS; k++) begin : g_word
        localparam unit_entry_t E = unit_entry(k);
        localparam int L = int'(E.len);
        always_comb begin
            hit[k] = 1'b0;
            for (int j = 0; j < L; j++) begin
                if (pos == LEN_W'(j)) begin
                    hit[k] = (E.word[8*(L-1-j) +: 8] == text_byte);
                end
            end
        end
        assign full_match[k] = cand_reg[k] && !long_reg && (LEN_W'(L) == len_reg);
        assign word_cls[k]   = E.cls;
    end

    // lowest index wins: second units first
    always_comb begin
        cls = UC_NONE;
        for (int k = NUM_WORDS - 1; k >= 0; k--) begin
            if (full_match[k]) begin
                cls = word_cls[k];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        num_next   = num_reg;
        big_next   = big_reg;
        len_next   = len_reg;
        long_next  = long_reg;
        cand_next  = cand_reg;
        shape_next = shape_reg;
        tok_push   = 1'b0;
        tok.is_end    = 1'b0;
        tok.do_pair   = 1'b0;
        tok.number    = num_reg;
        tok.too_big   = big_reg;
        tok.cls       = cls;
        tok.shape_err = shape_reg;
        if (byte_acc && end_marker) begin
            tok_push      = 1'b1;
            tok.is_end    = 1'b1;
            tok.do_pair   = (phase_reg == PH_UNIT);
            tok.shape_err = shape_reg || (phase_reg == PH_NUM) || (phase_reg == PH_SEP1);
            phase_next = PH_START;
            num_next   = '0;
            big_next   = 1'b0;
            len_next   = '0;
            long_next  = 1'b0;
            shape_next = 1'b0;
        end else if (byte_acc) begin
            case (phase_reg)
                PH_START, PH_SEP2: begin
                    if (is_dig) begin
                        num_next   = {60'd0, dig};
                        big_next   = 1'b0;
                        phase_next = PH_NUM;
                    end else if (!(phase_reg == PH_SEP2 && is_sep)) begin
                        shape_next = 1'b1;
                        phase_next = PH_BAD;
                    end
                end
                PH_NUM: begin
                    if (is_dig) begin
                        if (n10[67:64] != 4'd0) begin
                            big_next = 1'b1;
                        end else begin
                            num_next = n10[63:0];
                        end
                    end else if (is_sep) begin
                        phase_next = PH_SEP1;
                    end else begin
                        len_next   = LEN_W'(1);
                        long_next  = 1'b0;
                        cand_next  = hit;
                        phase_next = PH_UNIT;
                    end
                end
                PH_SEP1: begin
                    if (is_dig) begin
                        shape_next = 1'b1;
                        phase_next = PH_BAD;
                    end else if (!is_sep) begin
                        len_next   = LEN_W'(1);
                        long_next  = 1'b0;
                        cand_next  = hit;
                        phase_next = PH_UNIT;
                    end
                end
                PH_UNIT: begin
                    if (is_dig) begin
                        tok_push    = 1'b1;
                        tok.do_pair = 1'b1;
                        num_next    = {60'd0, dig};
                        big_next    = 1'b0;
                        phase_next  = PH_NUM;
                    end else if (is_spc) begin
                        tok_push    = 1'b1;
                        tok.do_pair = 1'b1;
                        phase_next  = PH_SEP2;
                    end else if (len_reg < LEN_W'(UNIT_MAX_CHARS)) begin
                        cand_next = cand_reg & hit;
                        len_next  = len_reg + LEN_W'(1);
                    end else begin
                        long_next = 1'b1;
                    end
                end
                default: phase_next = PH_BAD;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            num_reg   <= '0;
            big_reg   <= 1'b0;
            len_reg   <= '0;
            long_reg  <= 1'b0;
            shape_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
            big_reg   <= big_next;
            len_reg   <= len_next;
            long_reg  <= long_next;
            shape_reg <= shape_next;
        end
        cand_reg <= cand_next;
    end

endmodule

// ----- hw/rtl/dlp_queue.sv -----
// Small token queue between front and back end.
// Depends on dlp_pkg for the token type.
module dlp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dlp_pkg::token_t  push_tok,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output dlp_pkg::token_t  head_tok
);
    import dlp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    token_t            mem [DEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [PTR_W:0]    cnt_reg;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_tok = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_reg <= rd_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
        if (do_push) begin
            mem[wr_reg] <= push_tok;
        end
    end

endmodule

// ----- hw/rtl/dlp_back.sv -----
// Back end: scales each number by its unit, accumulates and emits results.
// Three stages: split multiply, product combine, accumulate. Depends on dlp_pkg.
module dlp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  dlp_pkg::token_t  q_tok,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [127:0]     m_tdata,
    output logic [1:0]       m_tuser
);
    import dlp_pkg::*;

    logic              en;
    // stage 1
    logic              v1_reg;
    token_t            t1_reg;
    logic [31+MUL_W:0] pl_reg, ph_reg;
    // stage 2
    logic              v2_reg;
    token_t            t2_reg;
    logic [63:0]       prod_reg;
    logic              movf_reg;
    logic [89:0]       prod_w;
    // stage 3 state
    logic [63:0]       sec_reg, sec_next, ns_reg, ns_next;
    status_t           err_reg, err_next;
    logic [64:0]       sum;
    logic              out_v_reg;
    logic [127:0]      out_d_reg;
    logic [1:0]        out_u_reg;
    status_t           st;
    logic [MUL_W-1:0]  mult;

    assign en    = !out_v_reg || m_tready;
    assign q_pop = en && !q_empty;
    assign mult  = cls_mult(q_tok.cls);
    assign prod_w = {1'b0, ph_reg, 32'd0} + {33'd0, pl_reg};

    always_comb begin
        err_next = err_reg;
        sec_next = sec_reg;
        ns_next  = ns_reg;
        sum = {1'b0, cls_is_sec(t2_reg.cls) ? sec_reg : ns_reg} + {1'b0, prod_reg};
        if (v2_reg && t2_reg.do_pair && err_reg == ST_OK) begin
            if (t2_reg.too_big) begin
                err_next = ST_OVERFLOW;
            end else if (t2_reg.cls == UC_NONE) begin
                err_next = ST_INVALID;
            end else if (movf_reg || sum[64]) begin
                err_next = ST_OVERFLOW;
            end else if (cls_is_sec(t2_reg.cls)) begin
                sec_next = sum[63:0];
            end else begin
                ns_next = sum[63:0];
            end
        end
        st = t2_reg.shape_err ? ST_INVALID : err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            err_reg   <= ST_OK;
            sec_reg   <= '0;
            ns_reg    <= '0;
        end else begin
            if (m_tready) begin
                out_v_reg <= 1'b0;
            end
            if (en) begin
                v1_reg <= q_pop;
                v2_reg <= v1_reg;
                if (v2_reg && t2_reg.is_end) begin
                    out_v_reg <= 1'b1;
                    err_reg   <= ST_OK;
                    sec_reg   <= '0;
                    ns_reg    <= '0;
                end else begin
                    err_reg <= err_next;
                    sec_reg <= sec_next;
                    ns_reg  <= ns_next;
                end
            end
        end
        if (en) begin
            t1_reg   <= q_tok;
            pl_reg   <= q_tok.number[31:0] * mult;
            ph_reg   <= q_tok.number[63:32] * mult;
            t2_reg   <= t1_reg;
            prod_reg <= prod_w[63:0];
            movf_reg <= (prod_w[89:64] != 26'd0);
            if (v2_reg && t2_reg.is_end) begin
                out_u_reg <= st;
                out_d_reg <= (st == ST_OK) ? {ns_next, sec_next} : 128'd0;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_u_reg;

endmodule

// ----- hw/rtl/duration_literal_parser.sv -----
// Duration literal parser: one text byte per cycle while the queue has room, one
// result per end marker. The end token passes the queue, back stages 1 and 2 and
// the result register. Front FSM and back accumulator each take one item per cycle.
// The back end stalls only when the result register is held by m_tready low.
// Synchronous active-low reset clears all parse and sum state; no clearing pass.
module duration_literal_parser #(
    parameter int UNIT_MAX_CHARS = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] text_byte
    input  logic         s_tlast,   // end_marker
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] total_seconds, [127:64] total_nanoseconds
    output logic [1:0]   m_tuser    // [1:0] status
);
    import dlp_pkg::*;

    logic   byte_acc;
    logic   tok_push;
    token_t tok, head_tok;
    logic   q_full, q_empty, q_pop;

    // front always keeps up; the queue alone back-pressures the input
    assign s_tready = !q_full;
    assign byte_acc = s_tvalid && s_tready;

    dlp_front #(.UNIT_MAX_CHARS(UNIT_MAX_CHARS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_acc   (byte_acc),
        .text_byte  (s_tdata),
        .end_marker (s_tlast),
        .tok_push   (tok_push),
        .tok        (tok)
    );

    dlp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (tok_push),
        .push_tok (tok),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_tok (head_tok)
    );

    dlp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_tok    (head_tok),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- bench/duration_literal_parser_tb.sv -----
// Self-checking bench for duration_literal_parser: streams duration texts byte by byte
// and checks status and both totals against a built-in parser model.
// Depends on dlp_pkg and the duration_literal_parser RTL.
`timescale 1ns / 100ps

module duration_literal_parser_tb;
    import dlp_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } text_item_t;

    typedef struct {
        status_t     st;
        logic [63:0] secs;
        logic [63:0] nsecs;
    } duration_t;

    typedef enum int {P_START, P_NUM, P_SEP1, P_UNIT, P_SEP2, P_BAD} parse_ph_t;

    localparam int UNIT_MAX = 12;
    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int LATENCY = 3;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    duration_literal_parser uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // ---------------- parser model state ----------------
    parse_ph_t   ph;
    logic [63:0] num;
    logic        num_big;
    logic [7:0]  word [UNIT_MAX];
    int          wlen;
    logic        wlong;
    logic [63:0] sec_sum, ns_sum;
    logic        bad_shape;
    status_t     pair_err;

    text_item_t  pending_items[$];
    duration_t   expected_durations[$];
    int          mismatches = 0;
    int          texts_checked = 0;
    int          bytes_sent = 0;
    bit          calm = 0;       // no idling in the tail of the run
    bit          hold_send = 0;  // sender pause until results drain

    function automatic void clear_parse();
        ph = P_START; num = 0; num_big = 0; wlen = 0; wlong = 0;
        sec_sum = 0; ns_sum = 0; bad_shape = 0; pair_err = ST_OK;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_gap(logic [7:0] c);
        return c == "," || c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit word_is(string w);
        if (wlong || w.len() != wlen) return 0;
        for (int i = 0; i < wlen; i++)
            if (word[i] != w[i]) return 0;
        return 1;
    endfunction

    // seconds multiplier of the held word, 0 if not a second unit
    function automatic logic [63:0] sec_scale();
        if (word_is("s") || word_is("sec") || word_is("secs") || word_is("seconds")) return 1;
        if (word_is("m") || word_is("min") || word_is("mins") || word_is("minutes")) return 60;
        if (word_is("h") || word_is("hr") || word_is("hrs") || word_is("hours")) return 3600;
        if (word_is("d") || word_is("day") || word_is("days")) return 86400;
        if (word_is("w") || word_is("wk") || word_is("wks") || word_is("week") ||
            word_is("weeks")) return 604800;
        if (word_is("y") || word_is("yr") || word_is("yrs") || word_is("year") ||
            word_is("years")) return 31536000;
        return 0;
    endfunction

    function automatic logic [63:0] ns_scale();
        if (word_is("n") || word_is("ns") || word_is("nsec") || word_is("nsecs") ||
            word_is("nanosec") || word_is("nanosecs") || word_is("nanosecond") ||
            word_is("nanoseconds")) return 1;
        if (word_is("ms") || word_is("msec") || word_is("msecs") || word_is("millisec") ||
            word_is("millisecs") || word_is("millisecond") ||
            word_is("milliseconds")) return 1000000;
        if (word_is("microsec") || word_is("microsecs") || word_is("microsecond") ||
            word_is("microseconds") || word_is("u") || word_is("us") || word_is("usec") ||
            word_is("usecs") || word_is("usecond") || word_is("useconds")) return 1000;
        return 0;
    endfunction

    // scaled add with overflow check; returns 0 on overflow
    function automatic bit accumulate(ref logic [63:0] sum, input logic [63:0] n, m);
        logic [127:0] p;
        logic [64:0]  s;
        p = n * {64'd0, m};
        if (p[127:64] != 0) return 0;
        s = {1'b0, sum} + {1'b0, p[63:0]};
        if (s[64]) return 0;
        sum = s[63:0];
        return 1;
    endfunction

    function automatic void close_pair();
        logic [63:0] m;
        if (pair_err != ST_OK) return;
        if (num_big) begin
            pair_err = ST_OVERFLOW;
            return;
        end
        m = sec_scale();
        if (m != 0) begin
            if (!accumulate(sec_sum, num, m)) pair_err = ST_OVERFLOW;
            return;
        end
        m = ns_scale();
        if (m == 0) begin
            pair_err = ST_INVALID;
            return;
        end
        if (!accumulate(ns_sum, num, m)) pair_err = ST_OVERFLOW;
    endfunction

    function automatic void begin_word(logic [7:0] c);
        wlen = 1; wlong = 0; word[0] = c; ph = P_UNIT;
    endfunction

    // advance the model by one accepted item, queuing a result on end marker
    function automatic void parse_item(text_item_t it);
        duration_t r;
        logic [63:0] d;
        logic [7:0] c;
        c = it.ch;
        if (it.fin) begin
            if (ph == P_UNIT) close_pair();
            else if (ph == P_NUM || ph == P_SEP1) bad_shape = 1;
            r.st = bad_shape ? ST_INVALID : pair_err;
            r.secs = (r.st == ST_OK) ? sec_sum : 64'd0;
            r.nsecs = (r.st == ST_OK) ? ns_sum : 64'd0;
            expected_durations.push_back(r);
            clear_parse();
            return;
        end
        case (ph)
            P_START, P_SEP2: begin
                if (is_dig(c)) begin
                    num = c - "0"; num_big = 0; ph = P_NUM;
                end else if (!(ph == P_SEP2 && is_gap(c))) begin
                    bad_shape = 1; ph = P_BAD;
                end
            end
            P_NUM: begin
                if (is_dig(c)) begin
                    d = c - "0";
                    if (num > (ALL1 - d) / 10) num_big = 1;
                    else num = num * 10 + d;
                end else if (is_gap(c)) ph = P_SEP1;
                else begin_word(c);
            end
            P_SEP1: begin
                if (is_dig(c)) begin
                    bad_shape = 1; ph = P_BAD;
                end else if (!is_gap(c)) begin_word(c);
            end
            P_UNIT: begin
                if (is_dig(c)) begin
                    close_pair();
                    num = c - "0"; num_big = 0; ph = P_NUM;
                end else if (c == " " || c == ",") begin
                    close_pair();
                    ph = P_SEP2;
                end else if (wlen < UNIT_MAX) begin
                    word[wlen] = c; wlen++;
                end else wlong = 1;
            end
            default: ph = P_BAD;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void put_text(string t, bit with_end = 1);
        text_item_t it;
        for (int i = 0; i < t.len(); i++) begin
            it.ch = t[i]; it.fin = 0;
            pending_items.push_back(it);
        end
        if (with_end) begin
            it.ch = $urandom; it.fin = 1;
            pending_items.push_back(it);
        end
    endfunction

    function automatic string pick_unit();
        string u[] = '{"s", "sec", "secs", "seconds", "m", "min", "mins", "minutes",
            "h", "hr", "hrs", "hours", "d", "day", "days", "w", "wk", "wks", "week",
            "weeks", "y", "yr", "yrs", "year", "years", "n", "ns", "nsec", "nsecs",
            "nanosec", "nanosecs", "nanosecond", "nanoseconds", "ms", "msec", "msecs",
            "millisec", "millisecs", "millisecond", "milliseconds", "microsec",
            "microsecs", "microsecond", "microseconds", "u", "us", "usec", "usecs",
            "usecond", "useconds", "x", "mss", "hour", "secondsxyzabc", "usecondsss"};
        return u[$urandom_range(0, u.size() - 1)];
    endfunction

    function automatic string pick_number();
        string s;
        int n;
        case ($urandom_range(0, 5))
            0: n = 20;
            1: n = $urandom_range(15, 22);
            default: n = $urandom_range(1, 4);
        endcase
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'("0") + 8'($urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string pick_gap();
        string g[] = '{"", "", " ", ", ", ",", "  ", "\t", "\n"};
        return g[$urandom_range(0, g.size() - 1)];
    endfunction

    // mostly well-formed texts with random content, some noise
    function automatic int make_random_text();
        string t;
        int pairs;
        t = "";
        if ($urandom_range(0, 9) < 8) begin
            pairs = $urandom_range(0, 4);
            for (int p = 0; p < pairs; p++) begin
                t = {t, pick_number(), pick_gap(), pick_unit()};
                if (p != pairs - 1) t = {t, pick_gap()};
            end
            if ($urandom_range(0, 9) == 0 && t.len() > 0) t[$urandom_range(0, t.len() - 1)] =
                8'($urandom);
        end else begin
            for (int i = $urandom_range(0, 10); i > 0; i--) t = {t, string'(8'($urandom))};
        end
        put_text(t);
        return t.len() + 1;
    endfunction

    // ---------------- driver ----------------
    int send_idle = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                parse_item('{s_tdata, s_tlast});
                bytes_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_idle > 0) begin
                    send_idle <= send_idle - 1;
                    s_tvalid <= 0;
                end else if (!calm && $urandom_range(0, 19) == 0) begin
                    send_idle <= $urandom_range(0, 15);
                    s_tvalid <= 0;
                end else if (!hold_send && pending_items.size() > 0) begin
                    text_item_t it;
                    it = pending_items.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= it.ch;
                    s_tlast <= it.fin;
                end else s_tvalid <= 0;
            end
        end
    end

    // ---------------- monitor ----------------
    int recv_idle = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                duration_t want;
                if (expected_durations.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d secs %0d ns %0d",
                                 m_tuser, m_tdata[63:0], m_tdata[127:64]);
                end else begin
                    want = expected_durations.pop_front();
                    texts_checked++;
                    if (m_tuser !== want.st || m_tdata[63:0] !== want.secs ||
                        m_tdata[127:64] !== want.nsecs) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp st %0d s %0d ns %0d, got st %0d s %0d ns %0d",
                                     texts_checked, want.st, want.secs, want.nsecs,
                                     m_tuser, m_tdata[63:0], m_tdata[127:64]);
                    end
                end
            end
            // receiver stall bursts
            if (recv_idle > 0) begin
                recv_idle <= recv_idle - 1;
                m_tready <= 0;
            end else if (!calm && $urandom_range(0, 14) == 0) begin
                recv_idle <= $urandom_range(0, 15);
                m_tready <= 0;
            end else m_tready <= 1;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        int sent;
        text_item_t zb;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        clear_parse();

        // directed texts
        put_text("");
        put_text("3 hours, 20ms");
        put_text("18446744073709551615s");
        put_text("18446744073709551616s");
        put_text("1m 1n 1u");
        put_text(" 5s");
        put_text("5");
        put_text("s");
        put_text("5 ,");
        put_text("5 s 6");
        put_text("99999999999y");
        put_text("5\ts");
        // zero byte inside a unit word
        put_text("1s", 0);
        zb.ch = 8'd0; zb.fin = 0;
        pending_items.push_back(zb);
        put_text("");
        put_text("4xyzabcdefghijklm 1s");
        put_text("7qq 99999999999999999999s");
        put_text({"1", 8'd255, " 2", 8'd128});
        put_text("1 seconds2minutes");
        sent = 178;

        // sender holds off until every result has drained
        wait (pending_items.size() == 0);
        hold_send = 1;
        wait (expected_durations.size() == 0 && !s_tvalid);
        repeat (LATENCY + 2) @(posedge aclk);
        hold_send = 0;

        while (sent < 1850) begin
            sent += make_random_text();
            if (sent > 1650) calm = 1;
            wait (pending_items.size() < 40);
        end
        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_durations.size() == 0);
        repeat (LATENCY + 4) @(posedge aclk);
        $display("Covered %0d text bytes/end markers, %0d results checked,", bytes_sent,
                 texts_checked);
        $display("including unit words, overflows, shape errors and stray bytes.");
        if (mismatches == 0 && expected_durations.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/dlp_pkg.sv
hw/rtl/dlp_front.sv
hw/rtl/dlp_queue.sv
hw/rtl/dlp_back.sv
hw/rtl/duration_literal_parser.sv
bench/duration_literal_parser_tb.sv
